// ===== rtl/core/plist_pkg.sv =====
// Package with shared sizes, codes and the cell command type of the positional list engine.
`default_nettype none

package plist_pkg;

  localparam int CAPACITY = 64;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_RETRIEVE = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic             rd_en;
    logic [IDX_W-1:0] slot;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/plist_cell.sv =====
// One storage cell of the list chain, holding a single entry.
`default_nettype none

module plist_cell (
  input  wire logic                         clk,
  input  wire plist_pkg::cell_cmd_t         cmd,
  input  wire logic [plist_pkg::IDX_W-1:0]  index,
  input  wire logic [plist_pkg::DATA_W-1:0] value_in,
  input  wire logic [plist_pkg::DATA_W-1:0] left_data,
  input  wire logic [plist_pkg::DATA_W-1:0] right_data,
  output logic      [plist_pkg::DATA_W-1:0] data,
  output logic      [plist_pkg::DATA_W-1:0] rd_term
);

  // An insert pulls from the lower neighbor above the slot, a delete
  // pulls from the upper neighbor from the slot on.
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (index > cmd.slot) begin
        data <= left_data;
      end else if (index == cmd.slot) begin
        data <= value_in;
      end
    end else if (cmd.del_en) begin
      if (index >= cmd.slot) begin
        data <= right_data;
      end
    end
  end

  assign rd_term = (cmd.rd_en && (index == cmd.slot)) ? data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/plist_ctrl.sv =====
// Operation decoder: checks count and position and forms the cell command.
`default_nettype none

module plist_ctrl (
  input  wire logic [1:0]                  op,
  input  wire logic [plist_pkg::POS_W-1:0] position,
  input  wire logic [plist_pkg::CNT_W-1:0] count,
  output plist_pkg::cell_cmd_t             cmd,
  output plist_pkg::status_t               status,
  output logic      [plist_pkg::CNT_W-1:0] count_next
);

  logic [plist_pkg::CMP_W-1:0] pos_w;
  logic [plist_pkg::CMP_W-1:0] cnt_w;
  logic [plist_pkg::CMP_W-1:0] slot_w;
  logic                        is_full;
  logic                        in_range;
  logic                        in_range_ins;

  assign pos_w        = plist_pkg::CMP_W'(position);
  assign cnt_w        = plist_pkg::CMP_W'(count);
  assign slot_w       = pos_w - plist_pkg::CMP_W'(1);
  assign is_full      = (cnt_w >= plist_pkg::CMP_W'(plist_pkg::CAPACITY));
  assign in_range     = (pos_w != '0) && (pos_w <= cnt_w);
  assign in_range_ins = (pos_w != '0) && (pos_w <= cnt_w + plist_pkg::CMP_W'(1));

  always_comb begin
    cmd.ins_en = 1'b0;
    cmd.del_en = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.slot   = slot_w[plist_pkg::IDX_W-1:0];
    status     = plist_pkg::ST_OK;
    count_next = count;
    unique case (plist_pkg::op_t'(op))
      plist_pkg::OP_INSERT: begin
        if (is_full) begin
          status = plist_pkg::ST_FULL;
        end else if (!in_range_ins) begin
          status = plist_pkg::ST_RANGE;
        end else begin
          cmd.ins_en = 1'b1;
          count_next = count + plist_pkg::CNT_W'(1);
        end
      end
      plist_pkg::OP_DELETE: begin
        if (count == '0) begin
          status = plist_pkg::ST_EMPTY;
        end else if (!in_range) begin
          status = plist_pkg::ST_RANGE;
        end else begin
          cmd.del_en = 1'b1;
          count_next = count - plist_pkg::CNT_W'(1);
        end
      end
      plist_pkg::OP_RETRIEVE: begin
        if (!in_range) begin
          status = plist_pkg::ST_RANGE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      default: begin
        status = plist_pkg::ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: a chain of entry cells with a decoder.
//
//  Channel   Ports                                       Transaction
//  command   start, busy, op, position, value_in         start high while busy is low
//  result    done, status, value_out, length,            done high for one cycle
//            is_empty, is_full
//
// Every command completes at once: the whole chain of cells shifts at the
// accepting edge, so a new command is taken at every edge and busy stays low.
// The result of a command is registered at its accepting edge and shown with
// done for exactly the following cycle; the receiver cannot stall it.
// Reset (rst, synchronous, active high) clears the entry count and the result
// strobe. Cell contents are not reset; only entries below the count are read.
`default_nettype none

module positional_list_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   op,
  input  wire logic [plist_pkg::POS_W-1:0]  position,
  input  wire logic [plist_pkg::DATA_W-1:0] value_in,
  output logic                              done,
  output logic      [1:0]                   status,
  output logic      [plist_pkg::DATA_W-1:0] value_out,
  output logic      [plist_pkg::LEN_W-1:0]  length,
  output logic                              is_empty,
  output logic                              is_full
);

  logic [plist_pkg::CNT_W-1:0] count;
  logic [plist_pkg::CNT_W-1:0] count_next;
  plist_pkg::cell_cmd_t        dec_cmd;
  plist_pkg::cell_cmd_t        cmd;
  plist_pkg::status_t          dec_status;
  logic                        accept;

  logic [plist_pkg::DATA_W-1:0] cell_data [plist_pkg::CAPACITY];
  logic [plist_pkg::DATA_W-1:0] cell_term [plist_pkg::CAPACITY];
  logic [plist_pkg::DATA_W-1:0] rd_value;

  // Every command completes in its accepting cycle, so the block never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  plist_ctrl u_ctrl (
    .op         (op),
    .position   (position),
    .count      (count),
    .cmd        (dec_cmd),
    .status     (dec_status),
    .count_next (count_next)
  );

  // The cells only act on a command that is actually accepted.
  always_comb begin
    cmd        = dec_cmd;
    cmd.ins_en = dec_cmd.ins_en && accept;
    cmd.del_en = dec_cmd.del_en && accept;
    cmd.rd_en  = dec_cmd.rd_en && accept;
  end

  // The chain: each cell sees its lower and upper neighbors. The ends see
  // zero, which is never taken into a live entry.
  for (genvar i = 0; i < plist_pkg::CAPACITY; i++) begin : g_cell
    logic [plist_pkg::DATA_W-1:0] left_data;
    logic [plist_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_left
      assign left_data = cell_data[i-1];
    end

    if (i == plist_pkg::CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
    end

    plist_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .index      (plist_pkg::IDX_W'(i)),
      .value_in   (value_in),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .rd_term    (cell_term[i])
    );
  end

  // Only the addressed cell drives a nonzero term on a retrieve.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < plist_pkg::CAPACITY; i++) begin
      rd_value = rd_value | cell_term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Result payload is captured with the command and held until the next one.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= dec_status;
      value_out <= rd_value;
      length    <= plist_pkg::LEN_W'(count_next);
      is_empty  <= (count_next == '0);
      is_full   <= (count_next == plist_pkg::CNT_W'(plist_pkg::CAPACITY));
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the positional list engine: directed and random commands.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plist_pkg::*;

  // One command waiting to be sent. The gap is the number of idle cycles the
  // sender inserts before it raises start for this command. When hold_for_drain
  // is set, the sender also waits until every outstanding result has come back.
  typedef struct {
    logic [1:0]        code;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;
    int                gap;
    bit                hold_for_drain;
  } list_cmd_t;

  // Everything one result transaction carries.
  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] value_out;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
    logic              is_full;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        op = OP_NOP;
  logic [POS_W-1:0]  position = '0;
  logic [DATA_W-1:0] value_in = '0;
  logic              busy;
  logic              done;
  logic [1:0]        status;
  logic [DATA_W-1:0] value_out;
  logic [LEN_W-1:0]  length;
  logic              is_empty;
  logic              is_full;

  positional_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .position  (position),
    .value_in  (value_in),
    .done      (done),
    .status    (status),
    .value_out (value_out),
    .length    (length),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  always #5 clk = ~clk;

  list_cmd_t    pending_cmds[$];
  list_result_t results_due[$];
  int           error_count = 0;
  int           gap_left = 0;

  // Stimulus-side bookkeeping: the generator tracks the list length so that it
  // can aim most positions inside the valid window and drive the list to both
  // full and empty. The predictor below keeps its own, independent state.
  int fill_level = 0;
  bit no_idle = 1'b0;

  // Predictor state: the list contents and the number of valid entries.
  logic [DATA_W-1:0] list_words[CAPACITY];
  int                list_len = 0;

  // Applies one command to the predicted list and returns the result the
  // block should report for it. Full is checked before the position on an
  // insert, and empty before the position on a delete.
  function automatic list_result_t apply_list_op(logic [1:0] code, logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] word);
    list_result_t r;
    int           p;
    p = pos;
    r.status    = ST_OK;
    r.value_out = '0;
    case (code)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = list_len; i > p - 1; i--) list_words[i] = list_words[i - 1];
          list_words[p - 1] = word;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      OP_RETRIEVE: begin
        if (p < 1 || p > list_len) r.status = ST_RANGE;
        else r.value_out = list_words[p - 1];
      end
      default: begin
        // The unused code does nothing and reports the list as it stands.
      end
    endcase
    r.length   = list_len[LEN_W-1:0];
    r.is_empty = (list_len == 0);
    r.is_full  = (list_len >= CAPACITY);
    return r;
  endfunction

  // Queues one command and advances the generator's view of the list length.
  function automatic void stage_cmd(logic [1:0] code, int pos, logic [DATA_W-1:0] word,
                                    bit hold_for_drain);
    list_cmd_t c;
    c.code           = code;
    c.pos            = pos[POS_W-1:0];
    c.word           = word;
    c.gap            = no_idle ? 0 : $urandom_range(0, 11);
    c.hold_for_drain = hold_for_drain;
    pending_cmds.push_back(c);
    if (code == OP_INSERT && fill_level < CAPACITY && pos >= 1 && pos <= fill_level + 1)
      fill_level++;
    else if (code == OP_DELETE && fill_level > 0 && pos >= 1 && pos <= fill_level)
      fill_level--;
  endfunction

  // Sender. A command is taken at an edge where start is high and busy is low.
  // Each signal gets a single nonblocking assignment per edge, so start stays
  // high without a glitch when commands follow back to back.
  always @(posedge clk) begin
    list_cmd_t c;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
      // The block has not taken the current command yet; hold everything.
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() != 0 &&
                 (!pending_cmds[0].hold_for_drain ||
                  (!start && !done && results_due.size() == 0))) begin
      // With start low and done low at this edge, the expectation queue is not
      // touched by the checker, so its size is stable here.
      c = pending_cmds.pop_front();
      start    <= 1'b1;
      op       <= c.code;
      position <= c.pos;
      value_in <= c.word;
      gap_left <= (pending_cmds.size() != 0) ? pending_cmds[0].gap : 0;
    end else begin
      start <= 1'b0;
    end
  end

  // Checker. An accepted command is predicted first, so a result that appears
  // at the same edge could still find its expectation; then any result on the
  // ports is compared with the oldest expectation, field by field.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (start && !busy) results_due.push_back(apply_list_op(op, position, value_in));
      if (done) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with no transaction outstanding (status %0d length %0d)",
                   $time, status, length);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            error_count++;
          end
          if (value_out !== want.value_out) begin
            $display("%0t: value_out expected %h, got %h", $time, want.value_out, value_out);
            error_count++;
          end
          if (length !== want.length) begin
            $display("%0t: length expected %0d, got %0d", $time, want.length, length);
            error_count++;
          end
          if (is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b, got %b", $time, want.is_empty, is_empty);
            error_count++;
          end
          if (is_full !== want.is_full) begin
            $display("%0t: is_full expected %b, got %b", $time, want.is_full, is_full);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          mode;
    int          phase_items;
    int          sent;
    int          roll;
    int          pos;
    logic [1:0]  code;
    logic [31:0] word;

    // Directed part: the empty list, both range edges of every operation, the
    // signed extremes of the data word, and the unused operation code.
    stage_cmd(OP_RETRIEVE, 1, 32'h0, 1'b0);           // retrieve from an empty list
    stage_cmd(OP_DELETE, 1, 32'h0, 1'b0);             // delete from an empty list
    stage_cmd(OP_DELETE, 0, 32'h0, 1'b0);             // empty wins over a bad position
    stage_cmd(OP_INSERT, 0, 32'h1234_5678, 1'b0);     // position zero
    stage_cmd(OP_INSERT, 2, 32'h1234_5678, 1'b0);     // one past count+1
    stage_cmd(OP_INSERT, 1, 32'h7FFF_FFFF, 1'b0);
    stage_cmd(OP_INSERT, 1, 32'h8000_0000, 1'b0);     // insert at the front
    stage_cmd(OP_INSERT, 3, 32'hFFFF_FFFF, 1'b0);     // append at count+1
    stage_cmd(OP_INSERT, 2, 32'h0000_0000, 1'b0);     // insert in the middle
    for (int i = 1; i <= 4; i++) stage_cmd(OP_RETRIEVE, i, 32'hFFFF_FFFF, 1'b0);
    stage_cmd(OP_RETRIEVE, 5, 32'h0, 1'b0);           // just past the count
    stage_cmd(OP_RETRIEVE, 127, 32'h0, 1'b0);         // top of the position field
    stage_cmd(OP_NOP, 127, 32'hFFFF_FFFF, 1'b0);
    stage_cmd(OP_DELETE, 0, 32'h0, 1'b0);
    stage_cmd(OP_DELETE, 5, 32'h0, 1'b0);
    stage_cmd(OP_DELETE, 4, 32'h0, 1'b0);             // delete the last entry
    stage_cmd(OP_DELETE, 1, 32'h0, 1'b0);             // delete the first entry
    stage_cmd(OP_RETRIEVE, 2, 32'h0, 1'b0);

    // Random part, in phases. Fill phases lean on inserts until the list is
    // full, drain phases lean on deletes until it is empty, and mixed phases
    // churn around the middle. Most positions fall in the valid window, with
    // the window edges favored; the rest cover the whole position field.
    sent = 0;
    while (sent < 700) begin
      mode        = $urandom_range(0, 2);
      phase_items = (mode == 2) ? 30 : 130;
      no_idle     = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_items && sent < 700; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: code = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                    (roll < 97) ? OP_RETRIEVE : OP_NOP;
          1: code = (roll < 70) ? OP_DELETE : (roll < 80) ? OP_INSERT :
                    (roll < 97) ? OP_RETRIEVE : OP_NOP;
          default: code = (roll < 35) ? OP_INSERT : (roll < 70) ? OP_DELETE :
                          (roll < 95) ? OP_RETRIEVE : OP_NOP;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          pos = $urandom_range(0, 127);
        end else if (code == OP_INSERT) begin
          pos = (roll < 25) ? 1 : (roll < 35) ? fill_level + 1 :
                $urandom_range(1, fill_level + 1);
        end else if (fill_level == 0) begin
          pos = $urandom_range(0, 127);
        end else begin
          pos = (roll < 25) ? 1 : (roll < 35) ? fill_level : $urandom_range(1, fill_level);
        end
        roll = $urandom_range(0, 19);
        word = (roll == 0) ? 32'h8000_0000 : (roll == 1) ? 32'h7FFF_FFFF :
               (roll == 2) ? 32'hFFFF_FFFF : (roll == 3) ? 32'h0 : $urandom();
        // The sender drains the block before the first random command and now
        // and then at the start of a phase.
        stage_cmd(code, pos, word, (sent == 0) || (k == 0 && $urandom_range(0, 2) == 0));
        sent++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Look at the queues between edges, where no clocked block is changing them.
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || results_due.size() != 0);
    repeat (5) @(negedge clk);

    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // A correct run needs about 750 transactions, roughly 100 us; this leaves a
  // wide margin.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
